/* sv/irptg_pkg.sv */
// Package for the IR remote pulse-train generator.
// Holds field widths, frame constants, register indexes and phase codes.
// No dependencies.
package irptg_pkg;

  // Frame layout
  localparam int unsigned COMMAND_BITS = 7;
  localparam int unsigned ADDRESS_BITS = 13;

  // Field and register widths
  localparam int unsigned CmdW     = 8;
  localparam int unsigned AddrW    = 13;
  localparam int unsigned HalfW    = 8;
  localparam int unsigned BitGapW  = 12;
  localparam int unsigned FrmGapW  = 16;
  localparam int unsigned RepW     = 3;
  localparam int unsigned CycW     = 7;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned BitIdxW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDevAddr  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHalfPer  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBitGap   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFrameGap = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRepeats  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStartCyc = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOneCyc   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegZeroCyc  = 3'd7;

  // Register reset values
  localparam logic [AddrW-1:0]   DevAddrRst  = 13'd0;
  localparam logic [HalfW-1:0]   HalfPerRst  = 8'd11;
  localparam logic [BitGapW-1:0] BitGapRst   = 12'd651;
  localparam logic [FrmGapW-1:0] FrameGapRst = 16'd11000;
  localparam logic [RepW-1:0]    RepeatsRst  = 3'd5;
  localparam logic [CycW-1:0]    StartCycRst = 7'd96;
  localparam logic [CycW-1:0]    OneCycRst   = 7'd48;
  localparam logic [CycW-1:0]    ZeroCycRst  = 7'd24;

  // Frame phase codes
  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhCmd   = 2'd1;
  localparam logic [1:0] PhAddr  = 2'd2;
  localparam logic [1:0] PhGap   = 2'd3;

  // Input op codes
  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

endpackage

/* sv/irptg_in_if.sv */
// Input channel of the IR pulse-train generator: valid/ready plus op and command.
// Depends on irptg_pkg.
interface irptg_in_if import irptg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [CmdW-1:0] command;

  modport source (output valid, output op, output command, input ready);
  modport sink   (input valid, input op, input command, output ready);
endinterface

/* sv/irptg_out_if.sv */
// Result channel of the IR pulse-train generator: valid/ready plus LED and busy.
// No dependencies.
interface irptg_out_if ();
  logic valid;
  logic ready;
  logic led_on;
  logic busy_res;

  modport source (output valid, output led_on, output busy_res, input ready);
  modport sink   (input valid, input led_on, input busy_res, output ready);
endinterface

/* sv/ir_remote_pulse_train_generator.sv */
// IR remote pulse-train generator, 20-bit frame transmitter.
// Each accepted item's result is registered in the output register, ready the cycle after acceptance.
// Throughput: one item per cycle; while a result waits untaken the input is held,
// and a new item enters in the cycle the waiting result is taken.
// Reset: async active low; config registers take their defaults, block idle, LED off.
module ir_remote_pulse_train_generator import irptg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  irptg_in_if.sink            in_s,
  irptg_out_if.source         out_s,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [AddrW-1:0]   dev_addr_q;
  logic [HalfW-1:0]   half_per_q;
  logic [BitGapW-1:0] bit_gap_q;
  logic [FrmGapW-1:0] frame_gap_q;
  logic [RepW-1:0]    repeats_q;
  logic [CycW-1:0]    start_cyc_q;
  logic [CycW-1:0]    one_cyc_q;
  logic [CycW-1:0]    zero_cyc_q;

  // Sequencer state
  logic [CmdW-1:0]    shot_code_q,    shot_code_d;
  logic               led_level_q,    led_level_d;
  logic [TimerW-1:0]  elapsed_q,      elapsed_d;
  logic [CycW-1:0]    burst_cyc_q,    burst_cyc_d;
  logic [BitIdxW-1:0] bit_idx_q,      bit_idx_d;
  logic [1:0]         frame_phase_q,  frame_phase_d;
  logic [RepW-1:0]    frame_cnt_q,    frame_cnt_d;

  // Output register
  logic               out_valid_q;
  logic               led_out_q;
  logic               busy_out_q;

  logic               in_fire;
  logic [TimerW-1:0]  elapsed_inc;
  logic [CycW-1:0]    target;
  logic               cur_bit;
  logic [15:0]        addr_ext;
  logic               burst_done;
  logic [BitIdxW:0]   bit_idx_nxt;

  assign in_s.ready = !out_valid_q || out_s.ready;
  assign in_fire    = in_s.valid && in_s.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DevAddrRst;
      half_per_q  <= HalfPerRst;
      bit_gap_q   <= BitGapRst;
      frame_gap_q <= FrameGapRst;
      repeats_q   <= RepeatsRst;
      start_cyc_q <= StartCycRst;
      one_cyc_q   <= OneCycRst;
      zero_cyc_q  <= ZeroCycRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDevAddr:  dev_addr_q  <= cfg_data_i[AddrW-1:0];
        RegHalfPer:  half_per_q  <= cfg_data_i[HalfW-1:0];
        RegBitGap:   bit_gap_q   <= cfg_data_i[BitGapW-1:0];
        RegFrameGap: frame_gap_q <= cfg_data_i[FrmGapW-1:0];
        RegRepeats:  repeats_q   <= cfg_data_i[RepW-1:0];
        RegStartCyc: start_cyc_q <= cfg_data_i[CycW-1:0];
        RegOneCyc:   one_cyc_q   <= cfg_data_i[CycW-1:0];
        RegZeroCyc:  zero_cyc_q  <= cfg_data_i[CycW-1:0];
        default: ;
      endcase
    end
  end

  assign elapsed_inc = (elapsed_q != {TimerW{1'b1}}) ? elapsed_q + 1'b1 : elapsed_q;
  assign addr_ext    = {{(16 - AddrW){1'b0}}, dev_addr_q};
  assign cur_bit     = (frame_phase_q == PhCmd) ? shot_code_q[bit_idx_q[2:0]]
                                                : addr_ext[bit_idx_q];
  assign target      = (frame_phase_q == PhStart) ? start_cyc_q
                     : (cur_bit ? one_cyc_q : zero_cyc_q);
  assign bit_idx_nxt = {1'b0, bit_idx_q} + 1'b1;

  always_comb begin
    shot_code_d   = shot_code_q;
    led_level_d   = led_level_q;
    elapsed_d     = elapsed_q;
    burst_cyc_d   = burst_cyc_q;
    bit_idx_d     = bit_idx_q;
    frame_phase_d = frame_phase_q;
    frame_cnt_d   = frame_cnt_q;
    burst_done    = 1'b0;

    if (in_s.op == OpStart) begin
      if (shot_code_q == '0 && in_s.command != '0) begin
        shot_code_d   = in_s.command;
        burst_cyc_d   = '0;
        bit_idx_d     = '0;
        frame_phase_d = PhStart;
        frame_cnt_d   = '0;
      end
    end else begin
      elapsed_d = elapsed_inc;
      if (shot_code_q != '0) begin
        if (frame_cnt_q >= repeats_q) begin
          // all frames sent: go idle, LED off
          shot_code_d   = '0;
          led_level_d   = 1'b0;
          burst_cyc_d   = '0;
          bit_idx_d     = '0;
          frame_phase_d = PhStart;
          frame_cnt_d   = '0;
        end else if (frame_phase_q == PhGap) begin
          if (elapsed_inc >= frame_gap_q) begin
            frame_cnt_d   = frame_cnt_q + 1'b1;
            frame_phase_d = PhStart;
            burst_cyc_d   = '0;
            bit_idx_d     = '0;
          end
        end else begin
          if (burst_cyc_q < target) begin
            // carrier: toggle every half period, count on falling edge
            if (elapsed_inc >= {{(TimerW - HalfW){1'b0}}, half_per_q}) begin
              led_level_d = !led_level_q;
              if (led_level_q) burst_cyc_d = burst_cyc_q + 1'b1;
              elapsed_d = '0;
            end
          end else begin
            burst_done = (elapsed_inc >= {{(TimerW - BitGapW){1'b0}}, bit_gap_q});
          end

          if (burst_done) begin
            burst_cyc_d = '0;
            unique case (frame_phase_q)
              PhStart: begin
                frame_phase_d = PhCmd;
                bit_idx_d     = '0;
              end
              PhCmd: begin
                if (bit_idx_nxt >= (BitIdxW + 1)'(COMMAND_BITS)) begin
                  frame_phase_d = PhAddr;
                  bit_idx_d     = '0;
                end else begin
                  bit_idx_d = bit_idx_nxt[BitIdxW-1:0];
                end
              end
              PhAddr: begin
                if (bit_idx_nxt >= (BitIdxW + 1)'(ADDRESS_BITS)) begin
                  frame_phase_d = PhGap;
                  bit_idx_d     = '0;
                end else begin
                  bit_idx_d = bit_idx_nxt[BitIdxW-1:0];
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shot_code_q   <= '0;
      led_level_q   <= 1'b0;
      elapsed_q     <= {TimerW{1'b1}};
      burst_cyc_q   <= '0;
      bit_idx_q     <= '0;
      frame_phase_q <= PhStart;
      frame_cnt_q   <= '0;
    end else if (in_fire) begin
      shot_code_q   <= shot_code_d;
      led_level_q   <= led_level_d;
      elapsed_q     <= elapsed_d;
      burst_cyc_q   <= burst_cyc_d;
      bit_idx_q     <= bit_idx_d;
      frame_phase_q <= frame_phase_d;
      frame_cnt_q   <= frame_cnt_d;
    end
  end

  // hold the result until taken; load the next one on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      led_out_q  <= led_level_d;
      busy_out_q <= (shot_code_d != '0);
    end
  end

  assign out_s.valid    = out_valid_q;
  assign out_s.led_on   = led_out_q;
  assign out_s.busy_res = busy_out_q;

  // Idle means LED off, phase at start and burst, bit and frame counters cleared
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (shot_code_q == '0) |-> (!led_level_q && frame_phase_q == PhStart &&
                            bit_idx_q == '0 && burst_cyc_q == '0 && frame_cnt_q == '0))
    else $error("idle state not cleared");

  // Bit index stays inside the field being sent
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_phase_q != PhCmd || {1'b0, bit_idx_q} < (BitIdxW + 1)'(COMMAND_BITS)) &&
    (frame_phase_q != PhAddr || {1'b0, bit_idx_q} < (BitIdxW + 1)'(ADDRESS_BITS)))
    else $error("bit index out of range");

  // A result that reports idle never shows the LED on
  a_out_idle_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !busy_out_q) |-> !led_out_q)
    else $error("LED on while idle");

  // An accepted item always produces a pending result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("result lost after accepted item");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the IR remote pulse-train generator.
// Predicts LED level and busy flag for every input item and checks each result in order.
// Depends on irptg_pkg, irptg_in_if, irptg_out_if and ir_remote_pulse_train_generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import irptg_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;

  typedef enum int unsigned {PaceFull, PaceSendIdle, PaceRecvStall, PaceBoth} pace_t;

  typedef struct packed {
    logic            op;
    logic [CmdW-1:0] cmd;
  } ir_item_t;

  typedef struct packed {
    logic led_on;
    logic busy;
  } ir_drive_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  irptg_in_if  in_ch ();
  irptg_out_if out_ch ();

  ir_remote_pulse_train_generator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_ch),
    .out_s      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  ir_item_t    pending_items[$];
  ir_drive_t   led_busy_due[$];
  ir_drive_t   seen_due;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int          budget;

  // Predicted configuration, mirrored at each register write
  logic [AddrW-1:0]   reg_addr      = DevAddrRst;
  logic [HalfW-1:0]   reg_half      = HalfPerRst;
  logic [BitGapW-1:0] reg_bit_gap   = BitGapRst;
  logic [FrmGapW-1:0] reg_frame_gap = FrameGapRst;
  logic [RepW-1:0]    reg_repeats   = RepeatsRst;
  logic [CycW-1:0]    reg_start_cyc = StartCycRst;
  logic [CycW-1:0]    reg_one_cyc   = OneCycRst;
  logic [CycW-1:0]    reg_zero_cyc  = ZeroCycRst;

  // Predicted transmitter state
  logic [CmdW-1:0]    tx_code    = '0;
  logic               tx_led     = 1'b0;
  logic [TimerW-1:0]  tx_elapsed = '1;
  logic [CycW-1:0]    tx_pulses  = '0;
  logic [BitIdxW-1:0] tx_bit     = '0;
  logic [1:0]         tx_phase   = PhStart;
  logic [RepW-1:0]    tx_frames  = '0;

  function automatic void tx_clear();
    tx_pulses = '0;
    tx_bit    = '0;
    tx_phase  = PhStart;
    tx_frames = '0;
  endfunction

  // Toggle the carrier while pulses remain, then report the end of the gap
  function automatic logic carrier_burst(logic [CycW-1:0] target);
    if (tx_pulses < target) begin
      if (tx_elapsed >= TimerW'(reg_half)) begin
        if (!tx_led) begin
          tx_led = 1'b1;
        end else begin
          tx_led    = 1'b0;
          tx_pulses = tx_pulses + 1'b1;
        end
        tx_elapsed = '0;
      end
      return 1'b0;
    end
    return tx_elapsed >= TimerW'(reg_bit_gap);
  endfunction

  function automatic void tx_tick();
    logic [CycW-1:0]   target;
    logic [TimerW-1:0] addr_wide;
    addr_wide = TimerW'(reg_addr);
    if (tx_elapsed != '1) tx_elapsed = tx_elapsed + 1'b1;
    if (tx_code == '0) return;
    if (tx_frames >= reg_repeats) begin
      tx_code = '0;
      tx_led  = 1'b0;
      tx_clear();
      return;
    end
    case (tx_phase)
      PhStart: begin
        if (carrier_burst(reg_start_cyc)) begin
          tx_phase  = PhCmd;
          tx_pulses = '0;
          tx_bit    = '0;
        end
      end
      PhCmd: begin
        target = tx_code[tx_bit[2:0]] ? reg_one_cyc : reg_zero_cyc;
        if (carrier_burst(target)) begin
          tx_pulses = '0;
          if (tx_bit + 1 >= COMMAND_BITS) begin
            tx_phase = PhAddr;
            tx_bit   = '0;
          end else begin
            tx_bit = tx_bit + 1'b1;
          end
        end
      end
      PhAddr: begin
        target = addr_wide[tx_bit] ? reg_one_cyc : reg_zero_cyc;
        if (carrier_burst(target)) begin
          tx_pulses = '0;
          if (tx_bit + 1 >= ADDRESS_BITS) begin
            tx_phase = PhGap;
            tx_bit   = '0;
          end else begin
            tx_bit = tx_bit + 1'b1;
          end
        end
      end
      PhGap: begin
        if (tx_elapsed >= TimerW'(reg_frame_gap)) begin
          tx_frames = tx_frames + 1'b1;
          tx_phase  = PhStart;
          tx_pulses = '0;
          tx_bit    = '0;
        end
      end
    endcase
  endfunction

  function automatic void tx_apply(logic op, logic [CmdW-1:0] cmd);
    if (op == OpStart) begin
      if (tx_code == '0 && cmd != '0) begin
        tx_code = cmd;
        tx_clear();
      end
    end else begin
      tx_tick();
    end
    led_busy_due.push_back('{led_on: tx_led, busy: tx_code != '0});
  endfunction

  // Rough tick count of one frame under the current settings
  function automatic int unsigned frame_ticks();
    int unsigned longest;
    longest = (reg_one_cyc > reg_zero_cyc) ? reg_one_cyc : reg_zero_cyc;
    return (reg_start_cyc + (COMMAND_BITS + ADDRESS_BITS) * longest) * 2 * (reg_half + 1)
           + (COMMAND_BITS + ADDRESS_BITS + 1) * (reg_bit_gap + 1) + reg_frame_gap + 2;
  endfunction

  // Input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        tx_apply(in_ch.op, in_ch.command);
        void'(pending_items.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.op      <= pending_items[0].op;
          in_ch.command <= pending_items[0].cmd;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (led_busy_due.size() == 0) begin
          $display("%0t ns: result with none pending: led_on %0b busy_res %0b",
                   $time, out_ch.led_on, out_ch.busy_res);
          mismatches++;
        end else begin
          seen_due = led_busy_due.pop_front();
          if (out_ch.led_on !== seen_due.led_on) begin
            $display("%0t ns: led_on expected %0b, got %0b",
                     $time, seen_due.led_on, out_ch.led_on);
            mismatches++;
          end
          if (out_ch.busy_res !== seen_due.busy) begin
            $display("%0t ns: busy_res expected %0b, got %0b",
                     $time, seen_due.busy, out_ch.busy_res);
            mismatches++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic queue_item(logic op, logic [CmdW-1:0] cmd);
    pending_items.push_back('{op: op, cmd: cmd});
    budget--;
  endtask

  task automatic queue_ticks(int unsigned count);
    while (count > 0 && budget > 0) begin
      queue_item(OpTick, CmdW'($urandom));
      count--;
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || led_busy_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_pace(pace_t pace);
    case (pace)
      PaceFull:      begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PaceSendIdle:  begin send_idle_pct = 60; recv_stall_pct = 0;  end
      PaceRecvStall: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      PaceBoth:      begin send_idle_pct = 7;  recv_stall_pct = 7;  end
    endcase
  endtask

  // Write one register; unused upper data bits carry random junk
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
    int unsigned         w;
    logic [CfgDataW-1:0] mask;
    logic [CfgDataW-1:0] data;
    w = CfgDataW;
    case (idx)
      RegDevAddr:  begin reg_addr      = AddrW'(value);   w = AddrW;   end
      RegHalfPer:  begin reg_half      = HalfW'(value);   w = HalfW;   end
      RegBitGap:   begin reg_bit_gap   = BitGapW'(value); w = BitGapW; end
      RegFrameGap: begin reg_frame_gap = FrmGapW'(value); w = FrmGapW; end
      RegRepeats:  begin reg_repeats   = RepW'(value);    w = RepW;    end
      RegStartCyc: begin reg_start_cyc = CycW'(value);    w = CycW;    end
      RegOneCyc:   begin reg_one_cyc   = CycW'(value);    w = CycW;    end
      RegZeroCyc:  begin reg_zero_cyc  = CycW'(value);    w = CycW;    end
    endcase
    mask = CfgDataW'((32'd1 << w) - 1);
    data = (CfgDataW'($urandom) & ~mask) | (CfgDataW'(value) & mask);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_settings(int unsigned addr, int unsigned half, int unsigned bit_gap,
                               int unsigned frame_gap, int unsigned repeats,
                               int unsigned start_cyc, int unsigned one_cyc,
                               int unsigned zero_cyc);
    write_reg(RegDevAddr, addr);
    write_reg(RegHalfPer, half);
    write_reg(RegBitGap, bit_gap);
    write_reg(RegFrameGap, frame_gap);
    write_reg(RegRepeats, repeats);
    write_reg(RegStartCyc, start_cyc);
    write_reg(RegOneCyc, one_cyc);
    write_reg(RegZeroCyc, zero_cyc);
  endtask

  initial begin
    int unsigned pick;
    in_ch.valid   = 1'b0;
    in_ch.op      = OpTick;
    in_ch.command = '0;
    out_ch.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Defaults: saturated timer toggles on the first tick after a start; zero and busy starts are dropped
    set_pace(PaceFull);
    budget = 100;
    queue_item(OpTick, 8'hFF);
    queue_item(OpStart, 8'h00);
    queue_item(OpStart, 8'h80);
    queue_item(OpStart, 8'h7F);
    queue_item(OpTick, 8'h00);
    queue_ticks(5);
    wait_drained();

    // No frames to send: go idle on the next tick, even mid-transmission
    write_reg(RegRepeats, 0);
    queue_item(OpTick, 8'h55);
    queue_item(OpStart, 8'hFF);
    queue_ticks(2);
    wait_drained();

    // Shorten the start burst while it runs: LED stays on into the gap
    load_settings(13'h1555, 1, 1, 1, 1, 3, 1, 0);
    queue_item(OpStart, 8'h01);
    queue_ticks(3);
    wait_drained();
    write_reg(RegStartCyc, 1);
    queue_ticks(3);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      set_pace(pace_t'(p % 4));
      budget = 200;
      case (p)
        3: load_settings(13'h1FFF, 255, 4095, 65535, 7, 127, 127, 127);
        6: load_settings(0, 0, 0, 0, 0, 0, 0, 0);
        8: load_settings($urandom, 0, 2, 5, 1, 127, 1, 127);
        default: load_settings($urandom, $urandom_range(0, 2), $urandom_range(0, 4),
                               $urandom_range(0, 12), $urandom_range(0, 3),
                               $urandom_range(0, 3), $urandom_range(0, 3),
                               $urandom_range(0, 3));
      endcase
      while (budget > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // full transmission with random command, run to completion when budget allows
          queue_item(OpStart, CmdW'($urandom_range(1, 255)));
          queue_ticks(reg_repeats * frame_ticks() + $urandom_range(1, 6));
        end else if (pick < 85) begin
          queue_ticks($urandom_range(1, 30));
        end else begin
          queue_item(OpStart, $urandom_range(0, 1) ? CmdW'(0) : CmdW'($urandom));
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
